FILE: hw/rtl/multitouch_slot_event_decoder_macros.svh
// Assertion helpers shared by the decoder RTL.
`ifndef MULTITOUCH_SLOT_EVENT_DECODER_MACROS_SVH
`define MULTITOUCH_SLOT_EVENT_DECODER_MACROS_SVH

// Same-cycle implication.
`define MTSED_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mtsed: assertion failed");

// Next-cycle implication.
`define MTSED_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mtsed: assertion failed");

`endif

FILE: hw/rtl/mtsed_pkg.sv
`timescale 1ns / 1ps

package mtsed_pkg;

   // Fixed field widths
   localparam int POS_W       = 12;
   localparam int ID_W        = 17;
   localparam int TYPE_W      = 5;
   localparam int CODE_W      = 10;
   localparam int VALUE_W     = 32;
   localparam int REQ_DATA_W  = 48;
   localparam int REQ_USER_W  = TYPE_W;
   localparam int RSP_DATA_W  = 48;
   localparam int RSP_PAD_W   = RSP_DATA_W - ID_W - 2 * POS_W;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 12;

   localparam int SLOTS_DEF      = 32;
   localparam int COORD_BITS_DEF = 12;
   localparam int MAX_RESULTS    = 32;
   localparam int TRACK_MAX      = 65536;

   // Event types and codes
   localparam logic [TYPE_W-1:0] EVT_SYN = 5'd0;
   localparam logic [TYPE_W-1:0] EVT_ABS = 5'd3;
   localparam logic [CODE_W-1:0] SYNC_REPORT = 10'd0;
   localparam logic [CODE_W-1:0] SYN_DROP    = 10'd3;
   localparam logic [CODE_W-1:0] ABS_SLOT    = 10'd47;
   localparam logic [CODE_W-1:0] ABS_POS_X   = 10'd53;
   localparam logic [CODE_W-1:0] ABS_POS_Y   = 10'd54;
   localparam logic [CODE_W-1:0] ABS_TRACK   = 10'd57;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_COORD_DISPLAY  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_INVERT_X       = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_SENSOR_MAX_X   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SENSOR_MAX_Y   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_DISPLAY_WIDTH  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_DISPLAY_HEIGHT = 3'd5;

   // Register reset values
   localparam logic [POS_W-1:0] SENSOR_MAX_X_RST   = 12'd1403;
   localparam logic [POS_W-1:0] SENSOR_MAX_Y_RST   = 12'd1871;
   localparam logic [POS_W-1:0] DISPLAY_WIDTH_RST  = 12'd1404;
   localparam logic [POS_W-1:0] DISPLAY_HEIGHT_RST = 12'd1874;

endpackage

FILE: hw/rtl/mtsed_scale.sv
`timescale 1ns / 1ps

module mtsed_scale #(
   parameter int COORD_BITS = mtsed_pkg::COORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [COORD_BITS-1:0]       pos,
   input  logic [mtsed_pkg::POS_W-1:0] max_val,
   input  logic [mtsed_pkg::POS_W-1:0] size,
   input  logic                        invert,
   output logic                        done,
   output logic [mtsed_pkg::POS_W-1:0] quot
);
   import mtsed_pkg::*;

   `include "multitouch_slot_event_decoder_macros.svh"

   localparam int CMPW  = (COORD_BITS > POS_W) ? COORD_BITS : POS_W;
   localparam int CNT_W = $clog2(POS_W);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(POS_W - 1);

   localparam logic [1:0] SC_IDLE = 2'd0;
   localparam logic [1:0] SC_MUL  = 2'd1;
   localparam logic [1:0] SC_DIV  = 2'd2;
   localparam logic [1:0] SC_DONE = 2'd3;

   logic [1:0]         phase_ff, phase_in;
   logic [POS_W-1:0]   m_ff, m_in;
   logic [POS_W-1:0]   n_ff, n_in;
   logic [POS_W-1:0]   size_ff, size_in;
   logic [POS_W-1:0]   rem_ff, rem_in;
   logic [POS_W-1:0]   low_ff, low_in;
   logic [POS_W-1:0]   q_ff, q_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic [POS_W-1:0]   m_clip;
   logic [CMPW-1:0]    pos_ext;
   logic [POS_W-1:0]   p_clamp;
   logic [2*POS_W-1:0] prod;
   logic [POS_W:0]     trial;
   logic               trial_ge;

   // zero maximum counts as one; position clamps to the maximum
   assign m_clip  = (max_val == '0) ? POS_W'(1) : max_val;
   assign pos_ext = CMPW'(pos);
   assign p_clamp = (pos_ext > CMPW'(m_clip)) ? m_clip : pos_ext[POS_W-1:0];

   assign prod     = (2*POS_W)'(size_ff) * (2*POS_W)'(n_ff);
   assign trial    = {rem_ff, low_ff[POS_W-1]};
   assign trial_ge = trial >= {1'b0, m_ff};

   always_comb begin
      phase_in = phase_ff;
      m_in     = m_ff;
      n_in     = n_ff;
      size_in  = size_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      if (start) begin
         m_in     = m_clip;
         n_in     = invert ? (m_clip - p_clamp) : p_clamp;
         size_in  = size;
         phase_in = SC_MUL;
      end else begin
         unique case (phase_ff)
            SC_MUL: begin
               // quotient fits POS_W bits, so the top half is already below m
               rem_in   = prod[2*POS_W-1:POS_W];
               low_in   = prod[POS_W-1:0];
               cnt_in   = '0;
               phase_in = SC_DIV;
            end
            SC_DIV: begin
               rem_in = trial_ge ? POS_W'(trial - {1'b0, m_ff}) : trial[POS_W-1:0];
               low_in = {low_ff[POS_W-2:0], 1'b0};
               q_in   = {q_ff[POS_W-2:0], trial_ge};
               cnt_in = cnt_ff + CNT_W'(1);
               if (cnt_ff == DIV_LAST) begin
                  phase_in = SC_DONE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= SC_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      m_ff    <= m_in;
      n_ff    <= n_in;
      size_ff <= size_in;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      q_ff    <= q_in;
      cnt_ff  <= cnt_in;
   end

   assign done = (phase_ff == SC_DONE);
   assign quot = q_ff;

   `MTSED_ASSERT_NXT(a_start_mul, clock, reset, start, phase_ff == SC_MUL)
   `MTSED_ASSERT_IMP(a_rem_below, clock, reset, phase_ff == SC_DIV, rem_ff < m_ff)
   `MTSED_ASSERT_IMP(a_quot_fits, clock, reset, phase_ff == SC_DONE, q_ff <= size_ff)

endmodule

FILE: hw/rtl/multitouch_slot_event_decoder.sv
`timescale 1ns / 1ps
// Channel  Direction  tdata                         tuser       tlast
// req      in         event_code, event_value       event_type  -
// rsp      out        contact_id, pos_x, pos_y      -           last
// csr      in         csr_we / csr_addr / csr_wdata, write only
//
// Tracking id and position events do a read-modify-write of the slot memory
// (one port each way); ignored, drop, slot and lift events write nothing to it.
// A report walks the slots, and each contact is read, scaled in display mode
// by a 12-step divider per axis, and then emitted.
// Reset clears the active and written bits per slot; no clearing pass.
// A stalled rsp word holds the walk but not the request side when idle.

module multitouch_slot_event_decoder #(
   parameter int SLOTS      = mtsed_pkg::SLOTS_DEF,
   parameter int COORD_BITS = mtsed_pkg::COORD_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mtsed_pkg::REQ_DATA_W-1:0] req_tdata,  // event_code, event_value
   input  logic [mtsed_pkg::REQ_USER_W-1:0] req_tuser,  // event_type
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mtsed_pkg::RSP_DATA_W-1:0] rsp_tdata,  // contact_id, pos_x, pos_y
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [mtsed_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [mtsed_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mtsed_pkg::*;

   `include "multitouch_slot_event_decoder_macros.svh"

   localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW   = $clog2(MAX_RESULTS + 1);
   localparam int MW   = ID_W + 2 * COORD_BITS;
   localparam int CMPW = (COORD_BITS > POS_W) ? COORD_BITS : POS_W;
   localparam logic [30:0]   COORD_TOP = 31'((1 << COORD_BITS) - 1);
   localparam logic [IW-1:0] LAST_IDX  = IW'(SLOTS - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_UPD   = 3'd1;
   localparam logic [2:0] ST_WALK  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_SCALE = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   localparam logic [1:0] UPD_TRK = 2'd0;
   localparam logic [1:0] UPD_X   = 2'd1;
   localparam logic [1:0] UPD_Y   = 2'd2;

   // configuration
   logic             cfg_display_ff, cfg_invx_ff;
   logic [POS_W-1:0] cfg_smx_ff, cfg_smy_ff, cfg_dw_ff, cfg_dh_ff;

   // control
   logic [2:0]       state_ff, state_in;
   logic [IW-1:0]    active_ff, active_in;
   logic             drop_ff, drop_in;
   logic [SLOTS-1:0] trk_act_ff, trk_act_in;
   logic [SLOTS-1:0] wr_vld_ff, wr_vld_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [1:0]       upd_kind_ff, upd_kind_in;
   logic [ID_W-1:0]  upd_val_ff, upd_val_in;

   // slot memory {id, x, y}
   logic [MW-1:0]    slot_mem [SLOTS];
   logic [MW-1:0]    rd_ff;
   logic             mem_re, mem_we;
   logic [IW-1:0]    mem_raddr;
   logic [MW-1:0]    mem_wdata, mem_base;

   // output word
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]  rsp_id_ff;
   logic [POS_W-1:0] rsp_x_ff, rsp_y_ff;
   logic             rsp_last_ff;

   logic                  req_acc;
   logic [TYPE_W-1:0]     ev_type;
   logic [CODE_W-1:0]     ev_code;
   logic [VALUE_W-1:0]    ev_value;
   logic                  ev_neg, slot_ok;
   logic [COORD_BITS-1:0] coord_sat;
   logic [ID_W-1:0]       id_sat;

   logic [ID_W-1:0]       rd_id;
   logic [COORD_BITS-1:0] rd_x, rd_y;
   logic [CMPW-1:0]       rd_x_ext, rd_y_ext;
   logic [POS_W-1:0]      raw_x, raw_y, emit_x, emit_y;
   logic                  hi_act, emit_last, rsp_free, rsp_load;

   logic                  sc_start, sx_done, sy_done;
   logic [POS_W-1:0]      sx_q, sy_q;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign ev_type    = req_tuser;
   assign ev_code    = req_tdata[CODE_W-1:0];
   assign ev_value   = req_tdata[CODE_W+VALUE_W-1:CODE_W];
   assign ev_neg     = ev_value[VALUE_W-1];
   assign slot_ok    = !ev_neg && (ev_value[30:0] < 31'(SLOTS));
   assign coord_sat  = ev_neg ? '0 :
                       (ev_value[30:0] > COORD_TOP) ? COORD_TOP[COORD_BITS-1:0] :
                       ev_value[COORD_BITS-1:0];
   assign id_sat     = (ev_value[30:0] > 31'(TRACK_MAX)) ? ID_W'(TRACK_MAX) :
                       ev_value[ID_W-1:0];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_display_ff <= 1'b0;
         cfg_invx_ff    <= 1'b0;
         cfg_smx_ff     <= SENSOR_MAX_X_RST;
         cfg_smy_ff     <= SENSOR_MAX_Y_RST;
         cfg_dw_ff      <= DISPLAY_WIDTH_RST;
         cfg_dh_ff      <= DISPLAY_HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_COORD_DISPLAY:  cfg_display_ff <= csr_wdata[0];
            REG_INVERT_X:       cfg_invx_ff    <= csr_wdata[0];
            REG_SENSOR_MAX_X:   cfg_smx_ff     <= csr_wdata[POS_W-1:0];
            REG_SENSOR_MAX_Y:   cfg_smy_ff     <= csr_wdata[POS_W-1:0];
            REG_DISPLAY_WIDTH:  cfg_dw_ff      <= csr_wdata[POS_W-1:0];
            REG_DISPLAY_HEIGHT: cfg_dh_ff      <= csr_wdata[POS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // memory read data fields; an unwritten entry counts as all zero in the update merge
   assign rd_id    = rd_ff[MW-1 -: ID_W];
   assign rd_x     = rd_ff[2*COORD_BITS-1 -: COORD_BITS];
   assign rd_y     = rd_ff[COORD_BITS-1:0];
   assign mem_base = wr_vld_ff[active_ff] ? rd_ff : '0;

   always_comb begin
      unique case (upd_kind_ff)
         UPD_X:   mem_wdata = {mem_base[MW-1 -: ID_W], upd_val_ff[COORD_BITS-1:0],
                               mem_base[COORD_BITS-1:0]};
         UPD_Y:   mem_wdata = {mem_base[MW-1:COORD_BITS], upd_val_ff[COORD_BITS-1:0]};
         default: mem_wdata = {upd_val_ff, mem_base[2*COORD_BITS-1:0]};
      endcase
   end

   assign mem_we    = (state_ff == ST_UPD);
   assign mem_re    = req_acc || (state_ff == ST_WALK);
   assign mem_raddr = (state_ff == ST_WALK) ? idx_ff : active_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[active_ff] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= slot_mem[mem_raddr];
      end
   end

   // raw output saturates to the field width
   assign rd_x_ext = CMPW'(rd_x);
   assign rd_y_ext = CMPW'(rd_y);
   assign raw_x    = (rd_x_ext > CMPW'({POS_W{1'b1}})) ? {POS_W{1'b1}} : rd_x_ext[POS_W-1:0];
   assign raw_y    = (rd_y_ext > CMPW'({POS_W{1'b1}})) ? {POS_W{1'b1}} : rd_y_ext[POS_W-1:0];
   assign emit_x   = cfg_display_ff ? sx_q : raw_x;
   assign emit_y   = cfg_display_ff ? sy_q : raw_y;

   assign sc_start = (state_ff == ST_READ) && cfg_display_ff;

   mtsed_scale #(.COORD_BITS(COORD_BITS)) u_scale_x (
      .clock   (clock),
      .reset   (reset),
      .start   (sc_start),
      .pos     (rd_x),
      .max_val (cfg_smx_ff),
      .size    (cfg_dw_ff),
      .invert  (cfg_invx_ff),
      .done    (sx_done),
      .quot    (sx_q)
   );

   mtsed_scale #(.COORD_BITS(COORD_BITS)) u_scale_y (
      .clock   (clock),
      .reset   (reset),
      .start   (sc_start),
      .pos     (rd_y),
      .max_val (cfg_smy_ff),
      .size    (cfg_dh_ff),
      .invert  (1'b1),
      .done    (sy_done),
      .quot    (sy_q)
   );

   // any contact left above the current slot
   always_comb begin
      hi_act = 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
         if (trk_act_ff[j] && (j > int'(idx_ff))) begin
            hi_act = 1'b1;
         end
      end
   end

   assign emit_last = !hi_act || (count_ff == CW'(MAX_RESULTS - 1));
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_load  = (state_ff == ST_EMIT) && rsp_free;

   always_comb begin
      state_in    = state_ff;
      active_in   = active_ff;
      drop_in     = drop_ff;
      trk_act_in  = trk_act_ff;
      wr_vld_in   = wr_vld_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      upd_kind_in = upd_kind_ff;
      upd_val_in  = upd_val_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (ev_type == EVT_SYN) begin
                  if (ev_code == SYN_DROP) begin
                     drop_in = 1'b1;
                  end else if (ev_code == SYNC_REPORT) begin
                     if (drop_ff) begin
                        drop_in = 1'b0;
                     end else begin
                        idx_in   = '0;
                        count_in = '0;
                        state_in = ST_WALK;
                     end
                  end
               end else if (!drop_ff && ev_type == EVT_ABS) begin
                  unique case (ev_code)
                     ABS_SLOT: begin
                        if (slot_ok) begin
                           active_in = ev_value[IW-1:0];
                        end
                     end
                     ABS_TRACK: begin
                        if (ev_neg) begin
                           trk_act_in[active_ff] = 1'b0;
                        end else begin
                           trk_act_in[active_ff] = 1'b1;
                           upd_kind_in = UPD_TRK;
                           upd_val_in  = id_sat;
                           state_in    = ST_UPD;
                        end
                     end
                     ABS_POS_X: begin
                        upd_kind_in = UPD_X;
                        upd_val_in  = ID_W'(coord_sat);
                        state_in    = ST_UPD;
                     end
                     ABS_POS_Y: begin
                        upd_kind_in = UPD_Y;
                        upd_val_in  = ID_W'(coord_sat);
                        state_in    = ST_UPD;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_UPD: begin
            wr_vld_in[active_ff] = 1'b1;
            state_in = ST_IDLE;
         end
         ST_WALK: begin
            if (trk_act_ff[idx_ff]) begin
               state_in = ST_READ;
            end else if (idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         ST_READ: begin
            state_in = cfg_display_ff ? ST_SCALE : ST_EMIT;
         end
         ST_SCALE: begin
            if (sx_done && sy_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               count_in = count_ff + CW'(1);
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = ST_WALK;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         drop_ff      <= 1'b0;
         trk_act_ff   <= '0;
         wr_vld_ff    <= '0;
         idx_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         drop_ff      <= drop_in;
         trk_act_ff   <= trk_act_in;
         wr_vld_ff    <= wr_vld_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      upd_kind_ff <= upd_kind_in;
      upd_val_ff  <= upd_val_in;
      if (rsp_load) begin
         rsp_id_ff   <= rd_id;
         rsp_x_ff    <= emit_x;
         rsp_y_ff    <= emit_y;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_y_ff, rsp_x_ff, rsp_id_ff};
   assign rsp_tlast  = rsp_last_ff;

   `MTSED_ASSERT_IMP(a_upd_after_accept, clock, reset, state_ff == ST_UPD, $past(req_acc))
   `MTSED_ASSERT_IMP(a_emit_active, clock, reset, state_ff == ST_EMIT, trk_act_ff[idx_ff])
   `MTSED_ASSERT_IMP(a_scale_lockstep, clock, reset, state_ff == ST_SCALE, sx_done == sy_done)
   `MTSED_ASSERT_NXT(a_last_ends_report, clock, reset, rsp_load && emit_last, state_ff == ST_IDLE)

endmodule
